// ===== sv/mdhu_pkg.sv =====
// Shared types and constants for the multiply/divide unit with HI and LO.
// No dependencies; used by mdhu_ctrl, mdhu_datapath and mult_div_hilo_unit.
`default_nettype none

package mdhu_pkg;

  // Arithmetic word size; operand bits above it are ignored
  localparam int WORD_BITS = 32;
  // Width of each operand field and of the result field on the ports
  localparam int FIELD_W   = 32;
  localparam int MODE_W    = 3;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam int IN_DATA_W = ((2 * FIELD_W + 7) / 8) * 8;

  localparam logic [31:0] HI_RESET = 32'hcafebabe;
  localparam logic [31:0] LO_RESET = 32'hcaf3bab3;

  typedef enum logic [MODE_W-1:0] {
    MODE_MULT,
    MODE_MULTU,
    MODE_DIV,
    MODE_DIVU,
    MODE_MTHI,
    MODE_MTLO,
    MODE_MFHI,
    MODE_MFLO
  } mode_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // latch operands and set up a divide
    logic step;    // one restoring divide iteration
    logic commit;  // update HI/LO and load the result register
  } mdhu_cmd_t;

endpackage

`default_nettype wire

// ===== sv/mdhu_ctrl.sv =====
// Controller state machine: handshakes, divide iteration count, commit timing.
// Depends on mdhu_pkg; drives mdhu_datapath through mdhu_cmd_t.
`default_nettype none

module mdhu_ctrl (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  input  wire  [mdhu_pkg::MODE_W-1:0]    in_tuser,
  output logic                           in_tready,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output mdhu_pkg::mdhu_cmd_t            cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                      state_r;
  logic [mdhu_pkg::CNT_W-1:0]  cnt_r;
  logic                        out_valid_r;
  logic                        accept;
  logic                        slot_free;
  logic                        is_div;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // Pick the long path for the divide codes
  always_comb begin
    case (mdhu_pkg::mode_t'(in_tuser))
      mdhu_pkg::MODE_DIV, mdhu_pkg::MODE_DIVU: is_div = 1'b1;
      default:                                 is_div = 1'b0;
    endcase
  end

  // Commands
  always_comb begin
    cmd.load   = accept;
    cmd.step   = (state_r == ST_DIV);
    cmd.commit = (state_r == ST_DONE) && slot_free;
  end

  // State, iteration count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            cnt_r   <= mdhu_pkg::CNT_W'(mdhu_pkg::WORD_BITS - 1);
            state_r <= is_div ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/mdhu_datapath.sv =====
// Datapath: operand registers, multiplier, restoring divider, HI/LO, result.
// Depends on mdhu_pkg; sequenced by mdhu_ctrl through mdhu_cmd_t.
`default_nettype none

module mdhu_datapath (
  input  wire                              clk,
  input  wire                              rst_n,
  input  mdhu_pkg::mdhu_cmd_t              cmd,
  input  wire  [mdhu_pkg::MODE_W-1:0]      in_mode,
  input  wire  [mdhu_pkg::FIELD_W-1:0]     in_operand_a,
  input  wire  [mdhu_pkg::FIELD_W-1:0]     in_operand_b,
  output logic [mdhu_pkg::FIELD_W-1:0]     out_read_value
);

  localparam int W = mdhu_pkg::WORD_BITS;

  mdhu_pkg::mode_t     mode_r;
  logic [W-1:0]        a_r, b_r;
  logic [W-1:0]        rem_r, quo_r, dmag_r;
  logic                neg_q_r, neg_r_r;
  logic [W-1:0]        hi_r, lo_r;
  logic [mdhu_pkg::FIELD_W-1:0] out_r;

  logic [W-1:0]        a_in, b_in;
  logic                div_signed;
  logic                a_neg, b_neg;
  logic [W-1:0]        a_mag, b_mag;
  logic [W:0]          shifted, diff;
  logic                mul_signed;
  logic signed [W:0]   mul_a, mul_b;
  logic signed [2*W+1:0] prod;
  logic [W-1:0]        quo_fix, rem_fix;

  assign a_in = in_operand_a[W-1:0];
  assign b_in = in_operand_b[W-1:0];

  // Divide setup: magnitudes and result signs
  assign div_signed = (mdhu_pkg::mode_t'(in_mode) == mdhu_pkg::MODE_DIV);
  assign a_neg      = div_signed && a_in[W-1];
  assign b_neg      = div_signed && b_in[W-1];
  assign a_mag      = a_neg ? (~a_in + 1'b1) : a_in;
  assign b_mag      = b_neg ? (~b_in + 1'b1) : b_in;

  // One restoring divide iteration
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dmag_r};

  // Full product, sign-extended for the signed multiply
  assign mul_signed = (mode_r == mdhu_pkg::MODE_MULT);
  assign mul_a      = $signed({mul_signed && a_r[W-1], a_r});
  assign mul_b      = $signed({mul_signed && b_r[W-1], b_r});
  assign prod       = mul_a * mul_b;

  // Apply signs to the divide results
  assign quo_fix = neg_q_r ? (~quo_r + 1'b1) : quo_r;
  assign rem_fix = neg_r_r ? (~rem_r + 1'b1) : rem_r;

  // Operands and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= mdhu_pkg::mode_t'(in_mode);
      a_r     <= a_in;
      b_r     <= b_in;
      rem_r   <= '0;
      quo_r   <= a_mag;
      dmag_r  <= b_mag;
      neg_q_r <= a_neg ^ b_neg;
      neg_r_r <= a_neg;
    end else if (cmd.step) begin
      if (!diff[W]) begin
        rem_r <= diff[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[W-1:0];
        quo_r <= {quo_r[W-2:0], 1'b0};
      end
    end
  end

  // HI and LO
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= W'(mdhu_pkg::HI_RESET);
      lo_r <= W'(mdhu_pkg::LO_RESET);
    end else if (cmd.commit) begin
      case (mode_r)
        mdhu_pkg::MODE_MULT, mdhu_pkg::MODE_MULTU: begin
          hi_r <= prod[2*W-1:W];
          lo_r <= prod[W-1:0];
        end
        mdhu_pkg::MODE_DIV, mdhu_pkg::MODE_DIVU: begin
          hi_r <= rem_fix;
          lo_r <= quo_fix;
        end
        mdhu_pkg::MODE_MTHI: hi_r <= a_r;
        mdhu_pkg::MODE_MTLO: lo_r <= a_r;
        default: ;
      endcase
    end
  end

  // Result beat: HI or LO for the move-from codes, zero otherwise
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      case (mode_r)
        mdhu_pkg::MODE_MFHI: out_r <= mdhu_pkg::FIELD_W'(hi_r);
        mdhu_pkg::MODE_MFLO: out_r <= mdhu_pkg::FIELD_W'(lo_r);
        default:             out_r <= '0;
      endcase
    end
  end

  assign out_read_value = out_r;

endmodule

`default_nettype wire

// ===== sv/mult_div_hilo_unit.sv =====
// Top level of the multiply/divide unit with HI and LO registers.
// Depends on mdhu_pkg, mdhu_ctrl and mdhu_datapath.
//
//  channel | direction | tdata                         | tuser
//  in_     | slave     | [31:0] operand_a [63:32] b    | [2:0] mode
//  out_    | master    | [31:0] read_value             | -
//
// Multiply, move-to and move-from go through setup and commit from the
// accepted beat to the result beat; divide adds 32 iterations of the radix-2
// restoring divider in between. One item is worked at a time; a new beat is
// taken as soon as the previous item commits, even while its result waits.
// Synchronous active-low reset sets HI to 0xcafebabe and LO to 0xcaf3bab3.
// A stalled output holds its result; commit waits until the output is free.
`default_nettype none

module mult_div_hilo_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [mdhu_pkg::IN_DATA_W-1:0]    in_tdata,   // operand_a, operand_b
  input  wire  [mdhu_pkg::MODE_W-1:0]       in_tuser,   // mode
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [mdhu_pkg::FIELD_W-1:0]      out_tdata   // read_value
);

  mdhu_pkg::mdhu_cmd_t cmd;

  mdhu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  mdhu_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_tuser),
    .in_operand_a   (in_tdata[mdhu_pkg::FIELD_W-1:0]),
    .in_operand_b   (in_tdata[2*mdhu_pkg::FIELD_W-1:mdhu_pkg::FIELD_W]),
    .out_read_value (out_tdata)
  );

endmodule

`default_nettype wire
